// ===== rtl/core/scsu_pkg.sv =====
// ----------------------------------------------------------------------------
// scsu_pkg
// Shared constants, types and control structs for the sine/cosine series unit.
// ----------------------------------------------------------------------------
package scsu_pkg;

    localparam int TERM_LIMIT_DEF = 12;
    localparam int FRAC_BITS_DEF  = 28;

    localparam int THR_W  = 29;
    localparam int MAXT_W = 4;
    localparam int CFG_W  = 29;

    localparam logic signed [31:0] PI_Q24     = 32'sd52707179;
    localparam logic signed [31:0] TWO_PI_Q24 = 32'sd105414357;

    localparam logic [THR_W-1:0]  THR_RST  = 29'd26844;
    localparam logic [MAXT_W-1:0] MAXT_RST = 4'd8;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_MAX_TERMS = 1'b1
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic fold;
        logic scale;
        logic square;
        logic init_sin;
        logic accum;
        logic start_cos;
        logic mul_a;
        logic mul_b;
        logic update;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic fold_hi;
        logic fold_lo;
        logic go;
        logic is_cos;
    } t_sts;

endpackage

// ===== rtl/core/scsu_datapath.sv =====
// ----------------------------------------------------------------------------
// scsu_datapath
// Angle fold, scaling, shared multiplier, reciprocal table and series sums.
// ----------------------------------------------------------------------------
module scsu_datapath #(
    parameter int FRAC_BITS  = scsu_pkg::FRAC_BITS_DEF,
    parameter int TERM_LIMIT = scsu_pkg::TERM_LIMIT_DEF
) (
    input  logic                          i_clk,
    input  scsu_pkg::t_cmd                i_cmd,
    output scsu_pkg::t_sts                o_sts,
    input  logic signed [31:0]            i_angle,
    input  logic [scsu_pkg::THR_W-1:0]    i_threshold,
    input  logic [scsu_pkg::MAXT_W-1:0]   i_max_terms,
    output logic signed [31:0]            o_sine_value,
    output logic signed [31:0]            o_cosine_value
);

    localparam int XW  = FRAC_BITS + 3;
    localparam int TW  = FRAC_BITS + 4;
    // x^2 reaches pi^2, just under 10
    localparam int X2W = FRAC_BITS + 5;
    localparam int SW  = FRAC_BITS + 6;
    localparam int PW  = 2 * FRAC_BITS + 9;
    localparam int QW  = PW - FRAC_BITS;
    localparam int RW  = FRAC_BITS + 1;
    localparam int NW  = $clog2(TERM_LIMIT + 1);
    localparam int IW  = $clog2(TERM_LIMIT);

    logic signed [31:0] r_ang;
    logic signed [XW-1:0] r_x;
    logic signed [X2W-1:0] r_x2;
    logic signed [TW-1:0] r_term;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] r_sin;
    logic signed [PW-1:0] r_prod;
    logic [NW-1:0]        r_n;
    logic                 r_cos;
    logic signed [31:0]   r_sine_out;
    logic signed [31:0]   r_cos_out;

    logic signed [63:0]   w_ang_ext;
    logic signed [XW-1:0] w_scaled;
    logic signed [QW-1:0] w_ma;
    logic signed [X2W-1:0] w_mb;
    logic signed [PW-1:0] w_mul;
    logic signed [PW-1:0] w_shift;
    logic [TW-1:0]        w_mag;
    logic [7:0]           w_lim;
    logic [RW-1:0]        w_rcp_sin [TERM_LIMIT];
    logic [RW-1:0]        w_rcp_cos [TERM_LIMIT];
    logic [RW-1:0]        w_rcp;
    logic [IW-1:0]        w_ridx;

    // reciprocal of each series divisor, rounded to nearest, worked out at elaboration
    for (genvar k = 0; k < TERM_LIMIT; k++) begin : g_rcp
        localparam longint N  = k + 1;
        localparam longint DS = (2 * N) * (2 * N + 1);
        localparam longint DC = (2 * N - 1) * (2 * N);
        localparam longint RS = ((64'sd1 <<< FRAC_BITS) + DS / 2) / DS;
        localparam longint RC = ((64'sd1 <<< FRAC_BITS) + DC / 2) / DC;
        assign w_rcp_sin[k] = RW'(RS);
        assign w_rcp_cos[k] = RW'(RC);
    end

    assign w_ang_ext = 64'(r_ang);

    if (FRAC_BITS >= 24) begin : g_up
        assign w_scaled = XW'(w_ang_ext <<< (FRAC_BITS - 24));
    end else begin : g_dn
        assign w_scaled = XW'(w_ang_ext >>> (24 - FRAC_BITS));
    end

    assign w_ridx  = IW'(r_n - 1'b1);
    assign w_rcp   = r_cos ? w_rcp_cos[w_ridx] : w_rcp_sin[w_ridx];
    assign w_shift = r_prod >>> FRAC_BITS;

    always_comb begin
        w_ma = QW'(r_term);
        w_mb = r_x2;
        if (i_cmd.square) begin
            w_ma = QW'(r_x);
            w_mb = X2W'(r_x);
        end else if (i_cmd.mul_b) begin
            w_ma = QW'(w_shift);
            w_mb = X2W'($signed({1'b0, w_rcp}));
        end
    end

    assign w_mul = PW'(w_ma) * PW'(w_mb);

    assign w_mag = r_term[TW-1] ? TW'(-r_term) : TW'(r_term);
    assign w_lim = (8'(i_max_terms) > 8'(TERM_LIMIT)) ? 8'(TERM_LIMIT) : 8'(i_max_terms);

    assign o_sts.fold_hi = r_ang > scsu_pkg::PI_Q24;
    assign o_sts.fold_lo = r_ang < -scsu_pkg::PI_Q24;
    assign o_sts.go      = (64'(w_mag) > 64'(i_threshold)) && (8'(r_n) < w_lim);
    assign o_sts.is_cos  = r_cos;

    function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (e < -64'sd2147483648)
            return 32'sh80000000;
        return 32'(e);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ang <= i_angle;
        end
        if (i_cmd.fold) begin
            if (o_sts.fold_hi)
                r_ang <= r_ang - scsu_pkg::TWO_PI_Q24;
            else if (o_sts.fold_lo)
                r_ang <= r_ang + scsu_pkg::TWO_PI_Q24;
        end
        if (i_cmd.scale) begin
            r_x <= w_scaled;
        end
        if (i_cmd.square || i_cmd.mul_a || i_cmd.mul_b) begin
            r_prod <= w_mul;
        end
        if (i_cmd.init_sin) begin
            r_x2   <= X2W'(w_shift);
            r_term <= TW'(r_x);
            r_sum  <= '0;
            r_n    <= '0;
            r_cos  <= 1'b0;
        end
        if (i_cmd.accum) begin
            r_sum <= r_sum + SW'(r_term);
            r_n   <= r_n + 1'b1;
        end
        if (i_cmd.start_cos) begin
            r_sin  <= r_sum;
            r_term <= TW'(1) <<< FRAC_BITS;
            r_sum  <= '0;
            r_n    <= '0;
            r_cos  <= 1'b1;
        end
        if (i_cmd.update) begin
            r_term <= TW'(-w_shift);
        end
        if (i_cmd.finish) begin
            r_sine_out <= sat32(r_sin);
            r_cos_out  <= sat32(r_sum);
        end
    end

    assign o_sine_value   = r_sine_out;
    assign o_cosine_value = r_cos_out;

endmodule

// ===== rtl/core/scsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// scsu_ctrl
// Sequencer: fold loop, squaring, then one series per function, and handshakes.
// ----------------------------------------------------------------------------
module scsu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_angle_valid,
    output logic           o_angle_ready,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    input  scsu_pkg::t_sts i_sts,
    output scsu_pkg::t_cmd o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FOLD   = 10'b0000000010,
        S_SCALE  = 10'b0000000100,
        S_SQUARE = 10'b0000001000,
        S_INIT   = 10'b0000010000,
        S_TEST   = 10'b0000100000,
        S_MUL_A  = 10'b0001000000,
        S_MUL_B  = 10'b0010000000,
        S_UPD    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_res_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_angle_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (!i_sts.fold_hi && !i_sts.fold_lo)
                    n_state = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_SQUARE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_INIT;
            end
            S_INIT: begin
                o_cmd.init_sin = 1'b1;
                n_state        = S_TEST;
            end
            S_TEST: begin
                if (i_sts.go) begin
                    o_cmd.accum = 1'b1;
                    n_state     = S_MUL_A;
                end else if (!i_sts.is_cos) begin
                    o_cmd.start_cos = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL_A: begin
                o_cmd.mul_a = 1'b1;
                n_state     = S_MUL_B;
            end
            S_MUL_B: begin
                o_cmd.mul_b = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_TEST;
            end
            S_DONE: begin
                // result register free, or being drained this cycle
                if (!r_out_valid || i_res_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_angle_ready = (r_state == S_IDLE);
    assign o_res_valid   = r_out_valid;

endmodule

// ===== rtl/core/sine_cosine_series_unit.sv =====
// Per angle: k fold steps (k from 0 to 20, one 2*pi add or subtract a cycle),
// then Ns terms of the sine series and Nc terms of the cosine series, each
// term using the one shared multiplier twice.
// One angle is taken at a time; a finished result waits in
// its output register while the next angle is taken.
// Reset: synchronous active low; clears control and loads register defaults.
// ----------------------------------------------------------------------------
// sine_cosine_series_unit
// Sine and cosine of a Q8.24 angle by Maclaurin series, Q4.28 results.
// ----------------------------------------------------------------------------
module sine_cosine_series_unit #(
    parameter int TERM_LIMIT = scsu_pkg::TERM_LIMIT_DEF,
    parameter int FRAC_BITS  = scsu_pkg::FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_index,
    input  logic [scsu_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_angle_valid,
    output logic                       o_angle_ready,
    input  logic signed [31:0]         i_angle,
    output logic                       o_res_valid,
    input  logic                       i_res_ready,
    output logic signed [31:0]         o_sine_value,
    output logic signed [31:0]         o_cosine_value
);

    logic [scsu_pkg::THR_W-1:0]  r_threshold;
    logic [scsu_pkg::MAXT_W-1:0] r_max_terms;
    scsu_pkg::t_cmd              w_cmd;
    scsu_pkg::t_sts              w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= scsu_pkg::THR_RST;
            r_max_terms <= scsu_pkg::MAXT_RST;
        end else if (i_cfg_we) begin
            unique case (scsu_pkg::t_cfg_idx'(i_cfg_index))
                scsu_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[scsu_pkg::THR_W-1:0];
                scsu_pkg::CFG_MAX_TERMS: r_max_terms <= i_cfg_data[scsu_pkg::MAXT_W-1:0];
                default: ;
            endcase
        end
    end

    scsu_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_angle_valid (i_angle_valid),
        .o_angle_ready (o_angle_ready),
        .o_res_valid   (o_res_valid),
        .i_res_ready   (i_res_ready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    scsu_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .TERM_LIMIT (TERM_LIMIT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_angle        (i_angle),
        .i_threshold    (r_threshold),
        .i_max_terms    (r_max_terms),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

endmodule

// ===== rtl/core/scsu_checker.sv =====
// ----------------------------------------------------------------------------
// scsu_checker
// Port-level checks for the sine/cosine series unit, bound to the top level.
// ----------------------------------------------------------------------------
module scsu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_angle_ready,
    input logic        i_angle_valid,
    input logic        o_res_valid,
    input logic        i_res_ready,
    input logic [31:0] o_sine_value,
    input logic [31:0] o_cosine_value
);

    // nothing comes out right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    // one angle at a time: busy after a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_angle_valid && o_angle_ready) |=> !o_angle_ready)
        else $error("angle taken while busy");

    // a new result only appears while the unit is busy
    a_new_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(!o_angle_ready))
        else $error("result without work");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=>
            (o_res_valid && $stable(o_sine_value) && $stable(o_cosine_value)))
        else $error("stalled result changed");

endmodule

bind sine_cosine_series_unit scsu_checker u_scsu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_angle_ready  (o_angle_ready),
    .i_angle_valid  (i_angle_valid),
    .o_res_valid    (o_res_valid),
    .i_res_ready    (i_res_ready),
    .o_sine_value   (o_sine_value),
    .o_cosine_value (o_cosine_value)
);

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Random and directed test of the sine/cosine series unit: angles are offered
// in bursts, results are drained with stalls, and every result is checked
// against a fixed-point series computed here for the current settings.
// ----------------------------------------------------------------------------
module tb;
    import scsu_pkg::*;

    localparam int FRAC     = 28;
    localparam int TLIMIT   = 12;
    localparam int SETTLE   = 200;
    localparam int WDOG_MAX = 6000;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic signed [31:0] sine;
        logic signed [31:0] cosine;
    } t_trig;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic                  i_cfg_index = 1'b0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_angle_valid = 1'b0;
    logic                  o_angle_ready;
    logic signed [31:0]    i_angle = '0;
    logic                  o_res_valid;
    logic                  i_res_ready = 1'b0;
    logic signed [31:0]    o_sine_value;
    logic signed [31:0]    o_cosine_value;

    sine_cosine_series_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_angle_valid  (i_angle_valid),
        .o_angle_ready  (o_angle_ready),
        .i_angle        (i_angle),
        .o_res_valid    (o_res_valid),
        .i_res_ready    (i_res_ready),
        .o_sine_value   (o_sine_value),
        .o_cosine_value (o_cosine_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [THR_W-1:0]  thr_mirror  = THR_RST;
    logic [MAXT_W-1:0] maxt_mirror = MAXT_RST;

    logic signed [31:0] angle_q[$];
    t_trig              trig_q[$];
    int                 mismatches = 0;
    int                 idle_cycles = 0;
    bit                 angle_taken = 0;
    int                 hold_req = 0;

    // floor(a*b / 2^FRAC), magnitude clamped to 2^62
    function automatic longint fx_mul(longint a, longint b);
        logic signed [127:0] p;
        p = 128'(signed'(a)) * 128'(signed'(b));
        p = p >>> FRAC;
        if (p > 128'sh4000_0000_0000_0000)
            p = 128'sh4000_0000_0000_0000;
        if (p < -128'sh4000_0000_0000_0000)
            p = -128'sh4000_0000_0000_0000;
        return longint'(p);
    endfunction

    function automatic longint fx_mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint series_sum(longint x2, longint start, bit cos_mode,
                                          int limit);
        longint sum, term, d, r;
        int n;
        sum = 0;
        term = start;
        n = 0;
        while (fx_mag(term) > longint'(thr_mirror) && n < limit) begin
            n++;
            sum += term;
            d = cos_mode ? (2*n - 1) * (2*n) : (2*n) * (2*n + 1);
            r = ((64'sd1 <<< FRAC) + d / 2) / d;
            term = -fx_mul(fx_mul(term, x2), r);
        end
        return sum;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_trig sincos_predict(logic signed [31:0] ang);
        longint a, x, x2;
        int limit;
        t_trig t;
        a = ang;
        limit = maxt_mirror > TLIMIT ? TLIMIT : int'(maxt_mirror);
        while (a > longint'(PI_Q24)) a -= longint'(TWO_PI_Q24);
        while (a < -longint'(PI_Q24)) a += longint'(TWO_PI_Q24);
        x = a <<< (FRAC - 24);
        x2 = fx_mul(x, x);
        t.sine = clamp32(series_sum(x2, x, 1'b0, limit));
        t.cosine = clamp32(series_sum(x2, 64'sd1 <<< FRAC, 1'b1, limit));
        return t;
    endfunction

    // monitor: both handshakes sampled at the rising edge
    always @(posedge i_clk) begin
        t_trig exp_t;
        if (i_rst_n) begin
            angle_taken = i_angle_valid && o_angle_ready;
            if (angle_taken)
                trig_q.push_back(sincos_predict(i_angle));
            if (o_res_valid && i_res_ready) begin
                if (trig_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result sin=%0d cos=%0d",
                                 o_sine_value, o_cosine_value);
                end else begin
                    exp_t = trig_q.pop_front();
                    if (exp_t.sine !== o_sine_value || exp_t.cosine !== o_cosine_value)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: sin exp %0d got %0d, cos exp %0d got %0d",
                                     exp_t.sine, o_sine_value, exp_t.cosine,
                                     o_cosine_value);
                    end
                end
            end
            if (angle_taken || (o_res_valid && i_res_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // driver: bursts of transactions separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_angle_valid || angle_taken)) begin
            angle_taken = 0;
            if (burst_left == 0 && gap_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
            end
            if (gap_left > 0) begin
                gap_left--;
                i_angle_valid <= 1'b0;
            end else if (angle_q.size() != 0) begin
                i_angle <= angle_q.pop_front();
                i_angle_valid <= 1'b1;
                burst_left--;
            end else begin
                i_angle_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern picked at random from four modes, plus one long hold-off
    int rx_cyc = 0;
    int rx_mode = 0;
    int hold_seen = 0;
    int hold_left = 0;
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_LEN;
        end
        if (rx_cyc % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        rx_cyc++;
        if (hold_left > 0) begin
            hold_left--;
            i_res_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: i_res_ready <= 1'b1;
                1: i_res_ready <= ($urandom_range(0, 3) != 0);
                2: i_res_ready <= ($urandom_range(0, 1) != 0);
                default: i_res_ready <= (rx_cyc % 7 < 2);
            endcase
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESHOLD)
            thr_mirror = val[THR_W-1:0];
        else
            maxt_mirror = val[MAXT_W-1:0];
    endtask

    task automatic queue_random_angles(int count);
        logic signed [31:0] a;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0, 1: a = $urandom;
                2:    a = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
                3:    a = PI_Q24 + $signed($urandom_range(0, 8)) - 4;
                4:    a = -PI_Q24 + $signed($urandom_range(0, 8)) - 4;
                default: a = $signed($urandom_range(0, 105414358)) - PI_Q24;
            endcase
            angle_q.push_back(a);
        end
    endtask

    task automatic drain_and_settle();
        while (angle_q.size() != 0 || i_angle_valid || trig_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes and fold boundaries, reset settings
        angle_q.push_back(32'sd0);
        angle_q.push_back(32'sh7fffffff);
        angle_q.push_back(32'sh80000000);
        angle_q.push_back(PI_Q24);
        angle_q.push_back(-PI_Q24);
        angle_q.push_back(PI_Q24 + 1);
        angle_q.push_back(-PI_Q24 - 1);
        angle_q.push_back(TWO_PI_Q24);
        angle_q.push_back(-TWO_PI_Q24);
        angle_q.push_back(32'sd1);
        angle_q.push_back(-32'sd1);
        angle_q.push_back(32'sd16777216);
        angle_q.push_back(-32'sd16777216);
        angle_q.push_back(32'sd26353589);
        angle_q.push_back(32'sh55555555);
        angle_q.push_back(32'shaaaaaaaa);
        queue_random_angles(170);
        drain_and_settle();

        cfg_write(CFG_THRESHOLD, 29'd0);
        cfg_write(CFG_MAX_TERMS, 29'd12);
        hold_req++;
        queue_random_angles(170);
        drain_and_settle();

        cfg_write(CFG_MAX_TERMS, 29'd15);
        queue_random_angles(170);
        drain_and_settle();

        cfg_write(CFG_MAX_TERMS, 29'd0);
        angle_q.push_back(PI_Q24);
        queue_random_angles(60);
        drain_and_settle();

        cfg_write(CFG_THRESHOLD, 29'h1fffffff);
        cfg_write(CFG_MAX_TERMS, 29'd8);
        queue_random_angles(120);
        drain_and_settle();

        cfg_write(CFG_THRESHOLD, 29'd268435456);
        cfg_write(CFG_MAX_TERMS, 29'd1);
        queue_random_angles(120);
        drain_and_settle();

        cfg_write(CFG_THRESHOLD, 29'd1);
        cfg_write(CFG_MAX_TERMS, 29'd4);
        queue_random_angles(170);
        drain_and_settle();

        for (int p = 0; p < 3; p++) begin
            cfg_write(CFG_THRESHOLD, $urandom_range(0, 1 << 20));
            cfg_write(CFG_MAX_TERMS, $urandom_range(1, 15));
            queue_random_angles(150);
            drain_and_settle();
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
